[src/lower_bound_search_defines.svh]
// ----------------------------------------------------------------------------
// lower_bound_search_defines
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef LOWER_BOUND_SEARCH_DEFINES_SVH
`define LOWER_BOUND_SEARCH_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lbs_pkg.sv]
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants of the lower-bound search block
// ----------------------------------------------------------------------------
package lbs_pkg;

    // fixed field widths of the stream beats
    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int BOUND_W = 11;
    localparam int CNT_W   = 11;

    // input beat kind, carried on tuser
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // commands from the stream front end to the search engine
    typedef struct packed {
        logic wr_en;
        logic start;
        logic take;
    } t_eng_cmd;

    // engine status back to the front end
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_stat;

endpackage

[src/lbs_engine.sv]
// ----------------------------------------------------------------------------
// lbs_engine
// entry store and halving search sequencer over a memory with a registered read
// ----------------------------------------------------------------------------
module lbs_engine
    import lbs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_eng_cmd         i_cmd,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_data,
    input  logic [CW-1:0]    i_count,
    output t_eng_stat        o_stat,
    output logic [CW-1:0]    o_bound
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    logic [WIDTH-1:0] mem [DEPTH];

    t_state           r_state, n_state;
    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [WIDTH-1:0] r_key, n_key;
    logic [WIDTH-1:0] r_rd_data;
    logic [CW-1:0]    w_mid;
    logic             w_ge;

    // probe point of the inclusive range lo..hi-1
    assign w_mid = r_lo + ((r_hi - r_lo - CW'(1)) >> 1);
    assign w_ge  = $signed(r_rd_data) >= $signed(r_key);

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_key   = r_key;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_lo    = '0;
                    n_hi    = i_count;
                    n_key   = i_data;
                    n_state = (i_count == '0) ? S_DONE : S_PROBE;
                end
            end
            S_PROBE: begin
                n_mid   = w_mid;
                n_state = S_CMP;
            end
            S_CMP: begin
                // hi doubles as the found index
                if (w_ge) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + CW'(1);
                end
                n_state = (n_lo < n_hi) ? S_PROBE : S_DONE;
            end
            S_DONE: begin
                if (i_cmd.take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
    end

    // writes only land while idle, so they never meet a probe read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[i_addr] <= i_data;
        end
        if (r_state == S_PROBE) begin
            r_rd_data <= mem[w_mid[AW-1:0]];
        end
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_bound     = r_hi;

endmodule

[src/lower_bound_search.sv]
// ----------------------------------------------------------------------------
// lower_bound_search
// sorted entry store answering lower-bound queries by halving search
// ----------------------------------------------------------------------------
// usage:
//   input stream (s_axis): tuser = kind, 0 writes one store entry, 1 queries.
//     tdata carries entry_index and value; a write beat stores value at
//     entry_index and returns nothing, a query beat returns one beat.
//   output stream (m_axis): tdata carries bound_index, the smallest index
//     below entries_in_use whose entry is >= the key, else entries_in_use.
//   config channel: i_cfg_data sets entries_in_use (clamped to DEPTH);
//     write it only while no query is in flight.
// flow:
//   write beats are accepted back to back.
//   a query runs up to P = ceil(log2(n+1)) probes after its accept, each one
//     store read and one signed compare, n being the clamped entries_in_use;
//     the result enters the output register as the engine returns to idle.
//   one query is in flight at a time; tready drops while it searches.
// reset: clears entries_in_use and all handshake state; the store contents
//   are undefined until loaded.
// stall: a finished result waits in the output register; the next item is
//   accepted meanwhile, and a second result waits in the engine until the
//   register drains.
// ----------------------------------------------------------------------------
module lower_bound_search
    import lbs_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CNT_W-1:0]   i_cfg_data,       // entries_in_use
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [47:0]        i_s_axis_tdata,   // [9:0] entry_index, [41:10] value
    input  logic               i_s_axis_tuser,   // [0] kind
    // output stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [15:0]        o_m_axis_tdata    // [10:0] bound_index
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]   r_count;
    logic               r_out_valid;
    logic [BOUND_W-1:0] r_out_bound;

    t_eng_cmd           w_cmd;
    t_eng_stat          w_stat;
    logic [CW-1:0]      w_bound;
    logic [CW-1:0]      w_count;
    logic [IDX_W-1:0]   w_idx;
    logic [VAL_W-1:0]   w_val;
    logic [WIDTH-1:0]   w_data;
    logic               w_in_beat;
    logic               w_in_range;

    // beat unpacking
    assign w_idx  = i_s_axis_tdata[IDX_W-1:0];
    assign w_val  = i_s_axis_tdata[IDX_W +: VAL_W];
    // only the low WIDTH bits count, zero extended if WIDTH is wider
    assign w_data = WIDTH'(w_val);

    // config register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // count above depth searches the whole store
    assign w_count = (32'(r_count) > DEPTH) ? CW'(DEPTH) : CW'(r_count);

    // accept only while the engine is idle
    assign o_s_axis_tready = w_stat.idle;
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    // writes past the store are dropped
    assign w_in_range      = 32'(w_idx) < DEPTH;

    assign w_cmd.wr_en = w_in_beat && (i_s_axis_tuser == KIND_WRITE) && w_in_range;
    assign w_cmd.start = w_in_beat && (i_s_axis_tuser == KIND_QUERY);
    assign w_cmd.take  = w_stat.done && (!r_out_valid || i_m_axis_tready);

    lbs_engine #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW),
        .CW    (CW)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (AW'(w_idx)),
        .i_data  (w_data),
        .i_count (w_count),
        .o_stat  (w_stat),
        .o_bound (w_bound)
    );

    // output register parts the engine from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.take) begin
            r_out_bound <= BOUND_W'(w_bound);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_bound};

endmodule

[src/lbs_checker.sv]
// ----------------------------------------------------------------------------
// lbs_checker
// port-level checks of the lower-bound search block, bound to the top level
// ----------------------------------------------------------------------------
`include "lower_bound_search_defines.svh"

module lbs_checker
    import lbs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_s_axis_tvalid,
    input logic               o_s_axis_tready,
    input logic               i_s_axis_tuser,
    input logic               o_m_axis_tvalid,
    input logic               i_m_axis_tready,
    input logic [15:0]        o_m_axis_tdata
);

    // stalled result beat stays up and unchanged
    `LBS_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid, "result dropped while stalled")
    `LBS_ASSERT_NEXT(a_out_stable, o_m_axis_tvalid && !i_m_axis_tready,
        $stable(o_m_axis_tdata), "result changed while stalled")

    // a query keeps the input closed while it searches
    `LBS_ASSERT_NEXT(a_query_busy,
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser == KIND_QUERY),
        !o_s_axis_tready, "input open during a search")

    // the answer never exceeds the store depth and its upper bits stay zero
    `LBS_ASSERT_SAME(a_bound_range, o_m_axis_tvalid,
        (32'(o_m_axis_tdata[10:0]) <= DEPTH) && (o_m_axis_tdata[15:11] == 5'b0),
        "bound index out of range")

endmodule

bind lower_bound_search lbs_checker #(.DEPTH(DEPTH)) u_lbs_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lower-bound search block
// ----------------------------------------------------------------------------
// loads the entry store over the input stream, sets entries_in_use through
// the config channel while the block is idle and sends lower-bound queries.
// every accepted query is answered by an in-bench halving search over its
// own copy of the store; results are checked in order against that copy.
// covers the empty store, counts above depth, duplicates, extreme keys and
// stores broken by stray writes, with random gaps and stalls on both streams
// and long output holds that back the block up
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int ITEMS_TARGET  = 2000;
    localparam int SETTLE_CYCLES = 32;     // quiet time after the last owed result
    localparam int HOLD_CYCLES   = 400;    // long output hold, fills the block
    localparam int REPORT_CAP    = 100;    // mismatch lines printed before going quiet

    localparam logic signed [VAL_W-1:0] KEY_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] KEY_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef struct packed {
        logic                      kind;
        logic [IDX_W-1:0]          entry_index;
        logic signed [VAL_W-1:0]   value;
    } search_beat_t;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // dut side signals, the driven ones known from time zero
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    search_beat_t       s_beat    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [15:0]        m_data;

    lower_bound_search #(
        .DEPTH (DEPTH),
        .WIDTH (VAL_W)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({{(48-IDX_W-VAL_W){1'b0}}, s_beat.value, s_beat.entry_index}),
        .i_s_axis_tuser  (s_beat.kind),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    // beats waiting for the sender, filled by the stimulus process
    search_beat_t pending_beats[$];
    // bounds the block owes us, oldest first
    logic [BOUND_W-1:0] expected_bounds[$];

    // predictor state: store copy and entries_in_use as the block sees them
    logic signed [VAL_W-1:0] store_copy [DEPTH];
    logic [CNT_W-1:0]        bound_count = '0;

    // stimulus-side view of the store, used to aim keys at loaded values
    logic signed [VAL_W-1:0] plan_store [DEPTH];

    // idling controls
    bit sender_gaps   = 1'b0;
    bit receiver_gaps = 1'b0;
    int hold_asked    = 0;
    int hold_served   = 0;

    // bookkeeping
    int   beats_queued   = 0;
    int   writes_taken   = 0;
    int   queries_taken  = 0;
    int   bounds_checked = 0;
    int   cfg_writes     = 0;
    int   mismatches     = 0;
    logic in_beat        = 1'b0;   // input beat accepted at the last rising edge

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // ------------------------------------------------------------------------
    // input side: prediction at the accepting edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : predictor
        int lo;
        int hi;
        int mid;
        int found;
        in_beat <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && s_valid && s_ready) begin
            if (s_beat.kind == KIND_WRITE) begin
                // entry_index is 10 bits, always inside the store
                store_copy[s_beat.entry_index] = s_beat.value;
                writes_taken++;
            end else begin
                // halving search over the first n entries, n clamped to depth
                found = (bound_count > DEPTH) ? DEPTH : int'(bound_count);
                lo    = 0;
                hi    = found - 1;
                while (lo <= hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (store_copy[mid] >= $signed(s_beat.value)) begin
                        found = mid;
                        hi    = mid - 1;
                    end else begin
                        lo = mid + 1;
                    end
                end
                expected_bounds.push_back(found[BOUND_W-1:0]);
                queries_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side: driver, changes inputs on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : sender
        int gap_left;
        if (i_rst_n && !(s_valid && !in_beat)) begin
            // nothing on the bus, or the last beat went through
            if (in_beat)
                gap_left = sender_gaps ? gap_len() : 0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                s_beat  <= pending_beats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output side: ready with random stalls, plus long holds on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : receiver
        int stall_left;
        if (hold_asked != hold_served) begin
            hold_served++;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0 && receiver_gaps) begin
            stall_left = gap_len();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // output side: in-order check of every result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : bound_monitor
        logic [BOUND_W-1:0] want;
        if (i_rst_n && m_valid && m_ready) begin
            bounds_checked++;
            if (expected_bounds.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t ns: unexpected result beat, expected none, actual %0d",
                             $time, m_data[BOUND_W-1:0]);
            end else begin
                want = expected_bounds.pop_front();
                if (m_data[BOUND_W-1:0] !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t ns: bound_index expected %0d, actual %0d",
                                 $time, want, m_data[BOUND_W-1:0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_write(input int idx, input logic signed [VAL_W-1:0] val);
        search_beat_t b;
        b.kind        = KIND_WRITE;
        b.entry_index = idx[IDX_W-1:0];
        b.value       = val;
        pending_beats.push_back(b);
        plan_store[idx] = val;
        beats_queued++;
    endtask

    task automatic queue_query(input logic signed [VAL_W-1:0] key);
        search_beat_t b;
        b.kind        = KIND_QUERY;
        b.entry_index = IDX_W'($urandom);   // don't care for queries
        b.value       = key;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // ascending values into entries 0..m-1, duplicates allowed,
    // written in index order or shuffled
    task automatic queue_sorted_load(input int m);
        logic signed [VAL_W-1:0] vals [DEPTH];
        int      order [DEPTH];
        longint  cur;
        int      step_cap;
        int      j;
        int      t;
        for (int i = 0; i < m; i++)
            order[i] = i;
        if ($urandom_range(1)) begin
            for (int i = m - 1; i > 0; i--) begin
                j        = $urandom_range(i);
                t        = order[i];
                order[i] = order[j];
                order[j] = t;
            end
        end
        cur      = ($urandom_range(3) == 0) ? longint'(KEY_MIN) : longint'($signed($urandom));
        step_cap = 1 << $urandom_range(22);
        for (int i = 0; i < m; i++) begin
            vals[i] = cur[VAL_W-1:0];
            cur     = cur + $urandom_range(step_cap);
            if (cur > longint'(KEY_MAX))
                cur = longint'(KEY_MAX);   // saturate, piles duplicates at the top
        end
        for (int i = 0; i < m; i++)
            queue_write(order[i], vals[order[i]]);
    endtask

    // keys near loaded values hit the compare edges; the rest are wide
    function automatic logic signed [VAL_W-1:0] pick_key(input int m);
        logic signed [VAL_W-1:0] k;
        int r;
        r = $urandom_range(9);
        if (m > 0 && r < 5) begin
            k = plan_store[$urandom_range(m - 1)];
            case ($urandom_range(2))
                0: k = k - 1;
                2: k = k + 1;
                default: ;
            endcase
        end else if (r < 8) begin
            k = $urandom;
        end else if (r == 8) begin
            k = KEY_MIN;
        end else begin
            k = KEY_MAX;
        end
        return k;
    endfunction

    // sender pause until every owed result is back and the block is quiet
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_beats.size() != 0 || s_valid || expected_bounds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_entries_in_use(input int n);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= n[CNT_W-1:0];
        do
            @(posedge i_clk);
        while (!cfg_ready);
        bound_count = n[CNT_W-1:0];
        cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int forced_counts [4] = '{1024, 2047, 0, 1025};
        int n;
        int m;
        int nq;
        int phase;
        bit hold_phase;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store after reset: every key answers 0, nothing is probed
        queue_query(KEY_MIN);
        queue_query(KEY_MAX);
        queue_query('0);

        // small sorted store with extreme values, top entry index too
        queue_write(0, KEY_MIN);
        queue_write(1, -5);
        queue_write(2, 7);
        queue_write(3, 1000);
        queue_write(DEPTH - 1, KEY_MAX);
        wait_drained();
        set_entries_in_use(4);
        queue_query(KEY_MIN);
        queue_query(-6);
        queue_query(-5);
        queue_query('0);
        queue_query(7);
        queue_query(8);
        queue_query(1000);
        queue_query(KEY_MAX);       // nothing qualifies, answers the count

        // single entry in use
        wait_drained();
        set_entries_in_use(1);
        queue_query(KEY_MIN);
        queue_query(-7);

        // break ascending order and let the halving search decide
        queue_write(1, 100);
        wait_drained();
        set_entries_in_use(4);
        queue_query(50);

        // fill the whole store so any count is safe from here on
        queue_sorted_load(DEPTH);

        phase = 0;
        while (beats_queued < ITEMS_TARGET) begin
            wait_drained();
            if (phase < 4) begin
                n = forced_counts[phase];
            end else begin
                case ($urandom_range(19))
                    0:       n = 0;
                    1:       n = DEPTH;
                    2:       n = $urandom_range(2047, DEPTH + 1);
                    3:       n = DEPTH - 1;
                    4:       n = $urandom_range(300, 65);
                    default: n = $urandom_range(64, 1);
                endcase
            end
            m          = (n > DEPTH) ? DEPTH : n;
            hold_phase = (phase % 12 == 1);
            sender_gaps   = !hold_phase && ($urandom_range(3) != 0);
            receiver_gaps = $urandom_range(3) != 0;
            set_entries_in_use(n);

            // fresh sorted prefix most of the time when it is cheap,
            // kept within the item budget
            if (!hold_phase && m > 0 && (beats_queued + m <= ITEMS_TARGET) &&
                $urandom_range(9) < ((m <= 128) ? 8 : 2))
                queue_sorted_load(m);

            // queries with random content, a few stray writes as noise
            nq = $urandom_range(60, 20);
            for (int i = 0; i < nq; i++) begin
                if ($urandom_range(99) < 8)
                    queue_write($urandom_range(DEPTH - 1), $urandom);
                else
                    queue_query(pick_key(m));
            end

            // output held off while the sender keeps offering queries
            if (hold_phase)
                hold_asked++;
            phase++;
        end
        wait_drained();

        $display("covered %0d store writes and %0d queries over %0d count settings",
                 writes_taken, queries_taken, cfg_writes);
        $display("checked %0d result beats, %0d mismatching", bounds_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit, several times the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("%0t ns: run limit reached, %0d results still owed",
                 $time, expected_bounds.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
